FILE: rtl/tsm_pkg.sv
// shared types and constants for the topological sort block
package tsm_pkg;

    // width of one adjacency row and of a node index
    localparam int ROW_W         = 8;
    localparam int NODE_IDX_W    = 3;
    localparam int MAX_NODES_DEF = 8;

    // sequencer states
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_EVAL,
        ST_EMIT,
        ST_CYCLE
    } state_t;

    // what the merge stage found for one pass
    typedef struct packed {
        logic [ROW_W-1:0] ready;     // nodes free of incoming edges this pass
        logic             none;      // no node is ready: remaining nodes form a cycle
        logic             all_done;  // after this pass every node is emitted
    } pass_status_t;

endpackage

FILE: rtl/topological_sort_matrix.sv
// top level: kahn topological sort over an adjacency matrix loaded row by row
// sequence: rows are taken one per transfer while loading; after the last row each pass
//   first evaluates, then emits its ready nodes one at a time, and a
//   cyclic graph ends with one closing result after its failed pass
// throughput: set by the single output register, one result per cycle within a pass
//   while m_tready holds; rows are not taken while a graph is being sorted
// reset: rst_n asynchronous active low clears sequencer, counts, masks and output valid;
//   stored rows are not cleared
module topological_sort_matrix
#(
    parameter int MAX_NODES = tsm_pkg::MAX_NODES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    // row transfer in
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] row_bits
    input  logic       s_tlast,   // last_row
    // result transfer out
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [2:0] node_index, [7:3] zero
    output logic [1:0] m_tuser,   // [0] node_valid, [1] is_cyclic
    output logic       m_tlast    // last
);

    localparam int NODE_CAP = (MAX_NODES < tsm_pkg::ROW_W) ? MAX_NODES : tsm_pkg::ROW_W;
    localparam int CNT_W    = $clog2(NODE_CAP + 1);
    localparam int IDX_W    = $clog2(NODE_CAP);

    tsm_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]               rows_loaded_reg, rows_loaded_next;
    logic [NODE_CAP-1:0]            removed_reg, removed_next;
    logic [tsm_pkg::ROW_W-1:0]      pending_reg, pending_next;
    logic                           done_reg, done_next;

    logic                           out_valid_reg, out_valid_next;
    logic [tsm_pkg::NODE_IDX_W-1:0] out_idx_reg, out_idx_next;
    logic                           out_nv_reg, out_nv_next;
    logic                           out_cyc_reg, out_cyc_next;
    logic                           out_last_reg, out_last_next;

    logic                           in_xfer;
    logic                           out_free;
    logic                           out_load;
    logic                           row_room;
    logic [NODE_CAP-1:0]            full;
    logic [tsm_pkg::ROW_W-1:0]      contrib [NODE_CAP];
    tsm_pkg::pass_status_t          status;
    logic [tsm_pkg::NODE_IDX_W-1:0] pick_idx;
    logic [tsm_pkg::ROW_W-1:0]      pick_oh;
    logic [tsm_pkg::ROW_W-1:0]      pending_left;

    // handshake helpers
    assign s_tready = (state_reg == tsm_pkg::ST_LOAD);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign row_room = (rows_loaded_reg < CNT_W'(NODE_CAP));

    // present nodes of the current graph
    always_comb
    begin
        for (int j = 0; j < NODE_CAP; j++)
        begin
            full[j] = (CNT_W'(j) < rows_loaded_reg);
        end
    end

    // node lanes
    for (genvar g = 0; g < NODE_CAP; g++)
    begin : g_lane
        tsm_lane u_lane
        (
            .clk     (clk),
            .wr_en   (in_xfer && row_room &&
                      (rows_loaded_reg[IDX_W-1:0] == IDX_W'(g))),
            .row_in  (s_tdata),
            .live    (full[g] && !removed_reg[g]),
            .contrib (contrib[g])
        );
    end

    // merge of lane results
    tsm_merge #(.NODE_CAP(NODE_CAP)) u_merge
    (
        .contrib (contrib),
        .full    (full),
        .removed (removed_reg),
        .status  (status)
    );

    // lowest pending node
    always_comb
    begin
        pick_idx = '0;
        pick_oh  = '0;
        for (int j = tsm_pkg::ROW_W - 1; j >= 0; j--)
        begin
            if (pending_reg[j])
            begin
                pick_idx = tsm_pkg::NODE_IDX_W'(j);
                pick_oh  = tsm_pkg::ROW_W'(1) << j;
            end
        end
    end

    assign pending_left = pending_reg & ~pick_oh;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tsm_pkg::ST_LOAD:
            begin
                if (in_xfer && s_tlast)
                begin
                    state_next = tsm_pkg::ST_EVAL;
                end
            end
            tsm_pkg::ST_EVAL:
            begin
                state_next = status.none ? tsm_pkg::ST_CYCLE : tsm_pkg::ST_EMIT;
            end
            tsm_pkg::ST_EMIT:
            begin
                if (out_free && (pending_left == '0))
                begin
                    state_next = done_reg ? tsm_pkg::ST_LOAD : tsm_pkg::ST_EVAL;
                end
            end
            tsm_pkg::ST_CYCLE:
            begin
                if (out_free)
                begin
                    state_next = tsm_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = tsm_pkg::ST_LOAD;
            end
        endcase
    end

    // datapath control and output loading
    always_comb
    begin
        rows_loaded_next = rows_loaded_reg;
        removed_next     = removed_reg;
        pending_next     = pending_reg;
        done_next        = done_reg;
        out_load         = 1'b0;
        out_idx_next     = out_idx_reg;
        out_nv_next      = out_nv_reg;
        out_cyc_next     = out_cyc_reg;
        out_last_next    = out_last_reg;
        unique case (state_reg)
            tsm_pkg::ST_LOAD:
            begin
                if (in_xfer && row_room)
                begin
                    rows_loaded_next = rows_loaded_reg + CNT_W'(1);
                end
            end
            tsm_pkg::ST_EVAL:
            begin
                pending_next = status.ready;
                removed_next = removed_reg | status.ready[NODE_CAP-1:0];
                done_next    = status.all_done;
            end
            tsm_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_idx_next  = pick_idx;
                    out_nv_next   = 1'b1;
                    out_cyc_next  = 1'b0;
                    out_last_next = done_reg && (pending_left == '0);
                    pending_next  = pending_left;
                    if ((pending_left == '0) && done_reg)
                    begin
                        rows_loaded_next = '0;
                        removed_next     = '0;
                    end
                end
            end
            tsm_pkg::ST_CYCLE:
            begin
                if (out_free)
                begin
                    out_load         = 1'b1;
                    out_idx_next     = '0;
                    out_nv_next      = 1'b0;
                    out_cyc_next     = 1'b1;
                    out_last_next    = 1'b1;
                    rows_loaded_next = '0;
                    removed_next     = '0;
                end
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
        out_valid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= tsm_pkg::ST_LOAD;
            rows_loaded_reg <= '0;
            removed_reg     <= '0;
            pending_reg     <= '0;
            done_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            rows_loaded_reg <= rows_loaded_next;
            removed_reg     <= removed_next;
            pending_reg     <= pending_next;
            done_reg        <= done_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_idx_reg  <= out_idx_next;
            out_nv_reg   <= out_nv_next;
            out_cyc_reg  <= out_cyc_next;
            out_last_reg <= out_last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(8 - tsm_pkg::NODE_IDX_W){1'b0}}, out_idx_reg};
    assign m_tuser  = {out_cyc_reg, out_nv_reg};
    assign m_tlast  = out_last_reg;

    // a new graph always starts with nothing removed
    a_load_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tsm_pkg::ST_LOAD) |-> (removed_reg == '0))
        else $error("removed mask not clear while loading");

    // pending nodes were already marked removed in their pass
    a_pending_removed: assert property (@(posedge clk) disable iff (!rst_n)
        ((pending_reg[NODE_CAP-1:0] & ~removed_reg) == '0))
        else $error("pending node not marked removed");

    // emitting always has a node to emit
    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tsm_pkg::ST_EMIT) |-> (pending_reg != '0))
        else $error("emit state with no pending node");

    // the last row starts a pass
    a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && s_tlast) |=> (state_reg == tsm_pkg::ST_EVAL))
        else $error("last row did not start the sort");

    // row count never passes capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (rows_loaded_reg <= CNT_W'(NODE_CAP)))
        else $error("row count beyond capacity");

endmodule

FILE: rtl/tsm_lane.sv
// one node lane: holds its adjacency row and offers its edges while the node is live
module tsm_lane
(
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [tsm_pkg::ROW_W-1:0] row_in,
    input  logic                      live,
    output logic [tsm_pkg::ROW_W-1:0] contrib
);

    logic [tsm_pkg::ROW_W-1:0] row_reg;

    // row storage, written once per graph
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row_reg <= row_in;
        end
    end

    // only edges of loaded, unemitted nodes count
    assign contrib = live ? row_reg : '0;

endmodule

FILE: rtl/tsm_merge.sv
// merge stage: combines lane edges into incoming flags and picks the ready nodes
module tsm_merge
#(
    parameter int NODE_CAP = tsm_pkg::MAX_NODES_DEF
)
(
    input  logic [tsm_pkg::ROW_W-1:0] contrib [NODE_CAP],
    input  logic [NODE_CAP-1:0]       full,
    input  logic [NODE_CAP-1:0]       removed,
    output tsm_pkg::pass_status_t     status
);

    logic [tsm_pkg::ROW_W-1:0] incoming;
    logic [NODE_CAP-1:0]       ready;

    // or of all live rows
    always_comb
    begin
        incoming = '0;
        for (int j = 0; j < NODE_CAP; j++)
        begin
            incoming = incoming | contrib[j];
        end
    end

    // a present, unemitted node with no incoming edge is ready
    assign ready = full & ~removed & ~incoming[NODE_CAP-1:0];

    always_comb
    begin
        status.ready    = tsm_pkg::ROW_W'(ready);
        status.none     = (ready == '0);
        status.all_done = (((removed | ready) & full) == full);
    end

endmodule

FILE: tb/sv/tb.sv
// testbench for topological_sort_matrix: random dags, cycles and overflow graphs checked per result
`timescale 1ns / 100ps

module tb;

    // node capacity of the block: the smaller of its node limit and the row width
    localparam int NODE_CAP    = (tsm_pkg::MAX_NODES_DEF < tsm_pkg::ROW_W) ?
                                 tsm_pkg::MAX_NODES_DEF : tsm_pkg::ROW_W;
    localparam int IDLE_LIMIT  = 2000;
    localparam int ROW_TARGET  = 230;
    localparam int TAIL_CYCLES = 40;

    // one result as the block reports it
    typedef struct packed {
        logic [tsm_pkg::NODE_IDX_W-1:0] node_index;
        logic                           node_valid;
        logic                           is_cyclic;
        logic                           last;
    } sort_result_t;

    // predicts the emitted order of each graph and checks it against the output stream
    class sort_scoreboard;
        logic [tsm_pkg::ROW_W-1:0] adj_rows [NODE_CAP];
        int unsigned               row_count   = 0;
        sort_result_t              order_q[$];
        int unsigned               errors      = 0;
        int unsigned               rows_seen   = 0;
        int unsigned               graphs      = 0;
        int unsigned               results     = 0;
        int unsigned               cyclic_runs = 0;

        function int unsigned pending();
            return order_q.size();
        endfunction

        // kahn passes over the stored rows; each pass emits all ready nodes in index order
        function void sort_graph();
            int unsigned               n;
            logic [tsm_pkg::ROW_W-1:0] full;
            logic [tsm_pkg::ROW_W-1:0] removed;
            logic [tsm_pkg::ROW_W-1:0] incoming;
            logic [tsm_pkg::ROW_W-1:0] ready;
            sort_result_t              r;
            n = (row_count > NODE_CAP) ? NODE_CAP : row_count;
            full = (n >= tsm_pkg::ROW_W) ? '1 : tsm_pkg::ROW_W'((1 << n) - 1);
            removed = '0;
            while ((removed & full) != full) begin
                incoming = '0;
                for (int j = 0; j < n; j++)
                    if (!removed[j])
                        incoming |= adj_rows[j];
                ready = full & ~removed & ~incoming;
                if (ready == '0) begin
                    r = '{node_index: '0, node_valid: 1'b0, is_cyclic: 1'b1, last: 1'b1};
                    order_q.push_back(r);
                    cyclic_runs++;
                    break;
                end
                removed |= ready;
                for (int j = 0; j < n; j++) begin
                    if (ready[j]) begin
                        r.node_index = tsm_pkg::NODE_IDX_W'(j);
                        r.node_valid = 1'b1;
                        r.is_cyclic  = 1'b0;
                        r.last       = ((removed & full) == full) &&
                                       ((ready >> (j + 1)) == '0);
                        order_q.push_back(r);
                    end
                end
            end
            row_count = 0;
            graphs++;
        endfunction

        // accepted row transfer: store while under capacity, sort on the last row
        function void note_row(logic [tsm_pkg::ROW_W-1:0] row_bits, logic last_row);
            rows_seen++;
            if (row_count < NODE_CAP) begin
                adj_rows[row_count] = row_bits;
                row_count++;
            end
            if (last_row)
                sort_graph();
        endfunction

        // accepted result transfer against the oldest prediction
        function void check_result(logic [7:0] data, logic [1:0] user, logic lst);
            sort_result_t want;
            if (order_q.size() == 0) begin
                $error("unexpected result: node_index=%0d node_valid=%0b is_cyclic=%0b last=%0b",
                       data[2:0], user[0], user[1], lst);
                errors++;
                return;
            end
            want = order_q.pop_front();
            results++;
            if (data[2:0] !== want.node_index) begin
                $error("node_index: expected %0d, got %0d", want.node_index, data[2:0]);
                errors++;
            end
            if (user[0] !== want.node_valid) begin
                $error("node_valid: expected %0b, got %0b", want.node_valid, user[0]);
                errors++;
            end
            if (user[1] !== want.is_cyclic) begin
                $error("is_cyclic: expected %0b, got %0b", want.is_cyclic, user[1]);
                errors++;
            end
            if (lst !== want.last) begin
                $error("last: expected %0b, got %0b", want.last, lst);
                errors++;
            end
            if (data[7:3] !== 5'd0) begin
                $error("tdata pad: expected 0, got %0h", data[7:3]);
                errors++;
            end
        endfunction
    endclass

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;

    sort_scoreboard sb;
    bit             quiet_phase = 1'b0;
    int unsigned    idle_cycles = 0;
    logic [7:0]     graph_rows [12];
    int unsigned    graph_len;

    topological_sort_matrix dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // 10 ns clock
    always #5 clk = ~clk;

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser, m_tlast);
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("no transfer for %0d cycles", IDLE_LIMIT);
            $display("topological_sort_matrix: mismatch");
            $finish;
        end
    end

    // result sink: random stall after each result transfer
    initial
    begin : result_sink
        int unsigned stall;
        wait (rst_n);
        @(posedge clk);
        m_tready <= 1'b1;
        forever begin
            @(posedge clk);
            if (m_tvalid && m_tready) begin
                stall = quiet_phase ? 0 : $urandom_range(0, 15);
                if (stall != 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                    m_tready <= 1'b1;
                end
            end
        end
    end

    // one row transfer after a random gap
    task automatic send_row(input logic [7:0] row_bits, input logic last_row);
        int unsigned gap;
        gap = quiet_phase ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= row_bits;
        s_tlast  <= last_row;
        do @(posedge clk); while (!s_tready);
        sb.note_row(row_bits, last_row);
    endtask

    // hold rows back until every predicted result has been taken
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    task automatic send_graph();
        for (int i = 0; i < graph_len; i++)
            send_row(graph_rows[i], i == graph_len - 1);
    endtask

    // random graph: mostly dags in a shuffled order, some with a back edge,
    // some with arbitrary rows and some with rows past capacity
    task automatic make_graph();
        int unsigned kind;
        int unsigned n;
        int unsigned density;
        int unsigned extra;
        int unsigned i;
        int unsigned k;
        int unsigned tmp;
        int unsigned order [8];
        logic [7:0]  full;
        kind    = $urandom_range(0, 9);
        n       = (kind == 9) ? 8 : $urandom_range(1, 8);
        density = $urandom_range(0, 100);
        full    = (n >= 8) ? 8'hFF : 8'((1 << n) - 1);
        for (i = 0; i < 8; i++)
            order[i] = i;
        for (i = n - 1; i > 0; i--) begin
            k = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[k];
            order[k] = tmp;
        end
        // edges only toward later nodes in the order; stray bits past the node count
        for (i = 0; i < n; i++) begin
            graph_rows[order[i]] = $urandom_range(0, 1) ? (8'($urandom) & ~full) : 8'h00;
            for (k = i + 1; k < n; k++)
                if ($urandom_range(0, 99) < density)
                    graph_rows[order[i]][order[k]] = 1'b1;
        end
        graph_len = n;
        case (kind)
            7: begin
                // back edge or self loop closes a cycle
                i = $urandom_range(0, n - 1);
                k = $urandom_range(0, i);
                graph_rows[order[i]][order[k]] = 1'b1;
            end
            8: begin
                for (i = 0; i < n; i++)
                    graph_rows[i] = 8'($urandom);
            end
            9: begin
                extra = $urandom_range(1, 3);
                for (i = 0; i < extra; i++)
                    graph_rows[8 + i] = 8'($urandom);
                graph_len += extra;
            end
            default: ;
        endcase
    endtask

    // reset, directed graphs, random graphs, drain and verdict
    initial
    begin : stimulus
        sb = new;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single node: plain, self loop, edges only to absent nodes
        send_row(8'h00, 1'b1);
        send_row(8'h01, 1'b1);
        send_row(8'hFE, 1'b1);
        // forward chain and reversed chain
        send_row(8'h02, 1'b0);
        send_row(8'h04, 1'b0);
        send_row(8'h00, 1'b1);
        send_row(8'h00, 1'b0);
        send_row(8'h01, 1'b0);
        send_row(8'h02, 1'b1);
        // two-node cycle
        send_row(8'h02, 1'b0);
        send_row(8'h01, 1'b1);
        // full eight-node chain, then rows past capacity with the last among them
        for (int i = 0; i < 7; i++)
            send_row(8'(1 << (i + 1)), 1'b0);
        send_row(8'h00, 1'b0);
        send_row(8'hFF, 1'b0);
        send_row(8'hFF, 1'b1);
        drain_results();

        // random graphs, some phases without idling
        while (sb.rows_seen < ROW_TARGET) begin
            quiet_phase = ($urandom_range(0, 3) == 0);
            make_graph();
            send_graph();
            if ($urandom_range(0, 7) == 0)
                drain_results();
        end
        s_tvalid <= 1'b0;
        quiet_phase = 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("sorted %0d graphs from %0d row transfers", sb.graphs, sb.rows_seen);
        $display("checked %0d results, %0d runs ended on a cycle", sb.results, sb.cyclic_runs);
        if (sb.errors == 0)
            $display("topological_sort_matrix: match");
        else
            $display("topological_sort_matrix: mismatch");
        $finish;
    end

endmodule

FILE: files.f
rtl/tsm_pkg.sv
rtl/tsm_lane.sv
rtl/tsm_merge.sv
rtl/topological_sort_matrix.sv
tb/sv/tb.sv
